// ===== rtl/core/bdot_pkg.sv =====
package bdot_pkg;

    // Fixed field widths
    localparam int ADDR_W    = 32;
    localparam int ID_W      = 16;
    localparam int TGT_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int KEY_W     = TGT_W + ID_W;
    localparam int WINDOWS   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // Queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;

    // Command codes
    localparam logic CMD_REQ = 1'b0;
    localparam logic CMD_RSP = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNMATCHED = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIN0_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN0_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN1_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN1_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIN2_BASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIN2_SIZE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIN3_BASE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WIN3_SIZE = 3'd7;

    // Classified item handed from front to back
    typedef struct packed {
        logic             cmd;
        logic             miss;
        logic [TGT_W-1:0] target;
        logic [ID_W-1:0]  txn_id;
    } t_item;

    // One result item
    typedef struct packed {
        logic [TGT_W-1:0]    target;
        logic                accepted;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } t_result;

endpackage

// ===== rtl/core/bdot_front.sv =====
module bdot_front #(
    parameter int TARGETS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bdot_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bdot_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            i_cmd,
    input  logic [bdot_pkg::ADDR_W-1:0]     i_addr,
    input  logic [bdot_pkg::ID_W-1:0]       i_txn_id,
    input  logic [bdot_pkg::TGT_W-1:0]      i_responder,
    output bdot_pkg::t_item                 o_item
);
    import bdot_pkg::*;

    logic [ADDR_W-1:0] r_base [WINDOWS];
    logic [ADDR_W-1:0] r_size [WINDOWS];
    logic [WINDOWS-1:0] win_hit;
    logic [TGT_W-1:0]   hit_idx;
    logic               hit_any;

    // Window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOWS; i++) begin
                r_base[i] <= '0;
                r_size[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIN0_BASE: r_base[0] <= i_cfg_wdata;
                REG_WIN0_SIZE: r_size[0] <= i_cfg_wdata;
                REG_WIN1_BASE: r_base[1] <= i_cfg_wdata;
                REG_WIN1_SIZE: r_size[1] <= i_cfg_wdata;
                REG_WIN2_BASE: r_base[2] <= i_cfg_wdata;
                REG_WIN2_SIZE: r_size[2] <= i_cfg_wdata;
                REG_WIN3_BASE: r_base[3] <= i_cfg_wdata;
                REG_WIN3_SIZE: r_size[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Parallel window compares, no wrap past the top of the address space
    always_comb begin
        for (int i = 0; i < WINDOWS; i++) begin
            win_hit[i] = (i < TARGETS) && (r_size[i] != '0) && (i_addr >= r_base[i])
                         && ((i_addr - r_base[i]) < r_size[i]);
        end
    end

    // Lowest-numbered window wins
    always_comb begin
        hit_idx = '0;
        hit_any = 1'b0;
        for (int i = WINDOWS - 1; i >= 0; i--) begin
            if (win_hit[i]) begin
                hit_idx = TGT_W'(i);
                hit_any = 1'b1;
            end
        end
    end

    // Classified item
    always_comb begin
        o_item.cmd    = i_cmd;
        o_item.txn_id = i_txn_id;
        if (i_cmd == CMD_RSP) begin
            o_item.miss   = 1'b0;
            o_item.target = i_responder;
        end else begin
            o_item.miss   = !hit_any;
            o_item.target = hit_idx;
        end
    end

endmodule

// ===== rtl/core/bdot_queue.sv =====
module bdot_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bdot_pkg::t_item i_item,
    input  logic            i_pop,
    output bdot_pkg::t_item o_item,
    output logic            o_vld,
    output logic            o_full
);
    import bdot_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_item = r_mem[r_rd_ptr];
    assign o_vld  = (r_count != '0);
    assign o_full = (r_count == CNT_W'(QUEUE_DEPTH));

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/bdot_back.sv =====
module bdot_back #(
    parameter int OUTSTANDING = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_vld,
    input  bdot_pkg::t_item   i_q_item,
    output logic              o_q_pop,
    output logic              o_res_vld,
    output bdot_pkg::t_result o_res
);
    import bdot_pkg::*;

    localparam int IDX_W = (OUTSTANDING > 1) ? $clog2(OUTSTANDING) : 1;
    localparam int CNT_W = $clog2(OUTSTANDING + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_MATCH
    } t_state;

    t_state           r_state;
    t_item            r_item;
    logic [OUTSTANDING-1:0] r_valid;
    logic [CNT_W-1:0] r_scan;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;
    logic [KEY_W-1:0] r_key_q;
    logic             r_res_vld;
    t_result          r_res;
    logic [KEY_W-1:0] r_keys [OUTSTANDING];

    logic [IDX_W-1:0] scan_idx;
    logic [KEY_W-1:0] item_key;
    logic             scan_end;
    logic             key_wr;
    logic             key_rd;
    logic             key_hit;

    // Mask a table index to the slot field
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

    assign scan_idx = r_scan[IDX_W-1:0];
    assign item_key = {r_item.target, r_item.txn_id};
    assign scan_end = (r_scan == CNT_W'(OUTSTANDING));
    assign key_wr   = (r_state == S_ALLOC) && !scan_end && !r_valid[scan_idx];
    assign key_rd   = (r_state == S_MATCH) && !scan_end;
    assign key_hit  = r_cmp_vld && r_valid[r_cmp_idx] && (r_key_q == item_key);
    assign o_q_pop  = (r_state == S_IDLE) && i_q_vld;
    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

    // Key store, one port used per cycle
    always_ff @(posedge i_clk) begin
        if (key_wr) begin
            r_keys[scan_idx] <= item_key;
        end
        if (key_rd) begin
            r_key_q <= r_keys[scan_idx];
        end
    end

    // Table engine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_scan    <= '0;
            r_cmp_vld <= 1'b0;
            r_cmp_idx <= '0;
            r_res_vld <= 1'b0;
            r_item    <= '0;
            r_res     <= '0;
        end else begin
            r_res_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_vld) begin
                        r_item    <= i_q_item;
                        r_scan    <= '0;
                        r_cmp_vld <= 1'b0;
                        if (i_q_item.cmd == CMD_RSP) begin
                            r_state <= S_MATCH;
                        end else if (i_q_item.miss) begin
                            // decode miss: answer at once, table untouched
                            r_res_vld <= 1'b1;
                            r_res     <= '{target: '0, accepted: 1'b0,
                                           status: ST_MISS, slot: '0};
                        end else begin
                            r_state <= S_ALLOC;
                        end
                    end
                end
                S_ALLOC: begin
                    // walk valid bits for the lowest free slot
                    if (scan_end) begin
                        r_res_vld <= 1'b1;
                        r_res     <= '{target: r_item.target, accepted: 1'b0,
                                       status: ST_FULL, slot: '0};
                        r_state   <= S_IDLE;
                    end else if (!r_valid[scan_idx]) begin
                        r_valid[scan_idx] <= 1'b1;
                        r_res_vld <= 1'b1;
                        r_res     <= '{target: r_item.target, accepted: 1'b1,
                                       status: ST_OK, slot: to_slot(scan_idx)};
                        r_state   <= S_IDLE;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_MATCH: begin
                    // read slot n while comparing slot n-1
                    r_cmp_vld <= key_rd;
                    r_cmp_idx <= scan_idx;
                    if (key_rd) begin
                        r_scan <= r_scan + 1'b1;
                    end
                    if (key_hit) begin
                        r_valid[r_cmp_idx] <= 1'b0;
                        r_res_vld <= 1'b1;
                        r_res     <= '{target: r_item.target, accepted: 1'b1,
                                       status: ST_OK, slot: to_slot(r_cmp_idx)};
                        r_state   <= S_IDLE;
                    end else if (r_cmp_vld && (r_cmp_idx == IDX_W'(OUTSTANDING - 1))) begin
                        r_res_vld <= 1'b1;
                        r_res     <= '{target: r_item.target, accepted: 1'b0,
                                       status: ST_UNMATCHED, slot: '0};
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/bus_demux_outstanding_tracker.sv =====
// Channel   Ports                                              Handshake
// config    i_cfg_we, i_cfg_idx, i_cfg_wdata                   write when i_cfg_we high
// item in   i_cmd, i_addr, i_txn_id, i_responder               start high, busy low
// result    o_target, o_accepted, o_status, o_slot             o_valid, one cycle
//
// Items are decoded on entry and held in a 2-deep queue; busy is high while it is full.
// An item passes from the queue to the table engine once the engine is idle; the engine
// holds one item at a time: a decode miss is answered at once, a request walks the valid
// bits for the lowest free slot (one valid bit checked per cycle), a response reads the
// key RAM (one key read per cycle, each compared in the next cycle); the result is registered.
// Reset is synchronous and empties the table and the queue; results cannot be held off.
module bus_demux_outstanding_tracker #(
    parameter int TARGETS     = 4,
    parameter int OUTSTANDING = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bdot_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bdot_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cmd,
    input  logic [bdot_pkg::ADDR_W-1:0]        i_addr,
    input  logic [bdot_pkg::ID_W-1:0]          i_txn_id,
    input  logic [bdot_pkg::TGT_W-1:0]         i_responder,
    output logic                               o_valid,
    output logic [bdot_pkg::TGT_W-1:0]         o_target,
    output logic                               o_accepted,
    output logic [bdot_pkg::STATUS_W-1:0]      o_status,
    output logic [bdot_pkg::SLOT_W-1:0]        o_slot
);
    import bdot_pkg::*;

    t_item   front_item;
    t_item   q_item;
    logic    q_vld;
    logic    q_full;
    logic    q_pop;
    logic    push;
    t_result res;

    assign busy = q_full;
    assign push = start && !q_full;

    // Decode and classify
    bdot_front #(
        .TARGETS (TARGETS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (i_cmd),
        .i_addr      (i_addr),
        .i_txn_id    (i_txn_id),
        .i_responder (i_responder),
        .o_item      (front_item)
    );

    // Item queue
    bdot_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_vld   (q_vld),
        .o_full  (q_full)
    );

    // Outstanding table
    bdot_back #(
        .OUTSTANDING (OUTSTANDING)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_vld   (q_vld),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_res_vld (o_valid),
        .o_res     (res)
    );

    assign o_target   = res.target;
    assign o_accepted = res.accepted;
    assign o_status   = res.status;
    assign o_slot     = res.slot;

endmodule
